### hw/rtl/stpg_pkg.sv
// Shared types, codes and constants for the siren tone pattern generator.
`timescale 1ns / 1ps

package stpg_pkg;

  // Pattern mode codes; codes 5 to 7 are silent
  typedef enum logic [2:0] {
    MODE_CONST = 3'd0,
    MODE_SWEEP = 3'd1,
    MODE_ALT   = 3'd2,
    MODE_PULSE = 3'd3,
    MODE_SOS   = 3'd4
  } mode_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_PATTERN_MODE = 3'd0,
    CFG_TONE_A_HZ    = 3'd1,
    CFG_TONE_B_HZ    = 3'd2,
    CFG_INTERVAL_MS  = 3'd3,
    CFG_PULSE_ON_MS  = 3'd4,
    CFG_PULSE_OFF_MS = 3'd5,
    CFG_BOOST_S      = 3'd6,
    CFG_DUTY_LEVELS  = 3'd7
  } cfg_idx_t;

  localparam logic [15:0] MIN_TONE_HZ  = 16'd100;
  localparam logic [15:0] SWEEP_MIN_MS = 16'd100;
  localparam logic [15:0] ALT_MIN_MS   = 16'd50;
  localparam logic [16:0] SOS_CYCLE_MS = 17'd4800;
  localparam logic [9:0]  MS_PER_S     = 10'd1000;
  localparam logic [6:0]  DUTY_FULL    = 7'd100;

  // x / 100 for x < 10000: (x * 10486) >> 20
  localparam logic [13:0] RECIP_100    = 14'd10486;
  localparam int          RECIP_SHIFT  = 20;

  // SOS on windows over one 4800 ms cycle: three shorts, three longs, three shorts,
  // each mark followed by a 200 ms gap
  function automatic logic sos_on(input logic [12:0] ph);
    logic s0, s1, s2, l0, l1, l2, e0, e1, e2;
    s0 = (ph < 13'd200);
    s1 = (ph >= 13'd400)  && (ph < 13'd600);
    s2 = (ph >= 13'd800)  && (ph < 13'd1000);
    l0 = (ph >= 13'd1200) && (ph < 13'd1800);
    l1 = (ph >= 13'd2000) && (ph < 13'd2600);
    l2 = (ph >= 13'd2800) && (ph < 13'd3400);
    e0 = (ph >= 13'd3600) && (ph < 13'd3800);
    e1 = (ph >= 13'd4000) && (ph < 13'd4200);
    e2 = (ph >= 13'd4400) && (ph < 13'd4600);
    return s0 | s1 | s2 | l0 | l1 | l2 | e0 | e1 | e2;
  endfunction

endpackage

### hw/rtl/stpg_divider.sv
// Pipelined restoring divider, one quotient bit per stage, with sideband.
`timescale 1ns / 1ps

module stpg_divider #(
  parameter int DW = 32,  // dividend width, must keep dividend < divisor << QW
  parameter int QW = 32,  // quotient width = stage count
  parameter int VW = 17,  // divisor / remainder width
  parameter int SW = 8    // sideband width
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_vld,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  input  logic [SW-1:0] side_in,
  output logic          out_vld,
  output logic [QW-1:0] quot,
  output logic [VW-1:0] rem,
  output logic [VW-1:0] div_out,
  output logic [SW-1:0] side_out
);

  logic          vld_r  [QW];
  logic [VW-1:0] rem_r  [QW];
  logic [QW-1:0] lo_r   [QW];
  logic [QW-1:0] q_r    [QW];
  logic [VW-1:0] div_r  [QW];
  logic [SW-1:0] side_r [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic          vld_in;
    logic [VW-1:0] rem_in;
    logic [VW-1:0] div_in;
    logic [QW-1:0] lo_in;
    logic [QW-1:0] q_in;
    logic [SW-1:0] side_s;
    logic [VW:0]   trial;
    logic [VW:0]   diff_s;
    logic          ge;

    if (k == 0) begin : g_first
      assign vld_in = in_vld;
      assign rem_in = VW'(dividend >> QW);
      assign lo_in  = dividend[QW-1:0];
      assign q_in   = '0;
      assign div_in = divisor;
      assign side_s = side_in;
    end else begin : g_rest
      assign vld_in = vld_r[k-1];
      assign rem_in = rem_r[k-1];
      assign lo_in  = lo_r[k-1];
      assign q_in   = q_r[k-1];
      assign div_in = div_r[k-1];
      assign side_s = side_r[k-1];
    end

    assign trial  = {rem_in, lo_in[QW-1]};
    assign diff_s = trial - {1'b0, div_in};
    assign ge     = (trial >= {1'b0, div_in});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? diff_s[VW-1:0] : trial[VW-1:0];
        lo_r[k]   <= lo_in << 1;
        q_r[k]    <= {q_in[QW-2:0], ge};
        div_r[k]  <= div_in;
        side_r[k] <= side_s;
      end
    end
  end

  assign out_vld  = vld_r[QW-1];
  assign quot     = q_r[QW-1];
  assign rem      = rem_r[QW-1];
  assign div_out  = div_r[QW-1];
  assign side_out = side_r[QW-1];

endmodule

### hw/rtl/siren_tone_pattern_generator.sv
// Top level of the siren tone pattern generator.
`timescale 1ns / 1ps

// Maps elapsed play time in ms to one result beat: tone on/off, frequency, duty
// percent and PWM compare count. One beat is accepted every cycle while in_ready
// is high; each result passes through 51 register stages (input register, a
// 32-stage divider for the pattern phase, a product stage, a 16-stage divider for
// the sweep scaling, output register). The whole pipe holds in place while the
// output register is full and out_ready is low, so in_ready simply follows
// out_ready then.
// Configuration writes are taken at any time but should only be made while the
// pipe is empty; all configuration registers reset to 0 (constant mode, a 100 Hz tone at 0 duty).
module siren_tone_pattern_generator #(
  parameter int DUTY_BITS = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_elapsed_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_tone_on,
  output logic [15:0] out_tone_hz,
  output logic [6:0]  out_duty_percent,
  output logic [9:0]  out_duty_count,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [20:0] cfg_data
);

  import stpg_pkg::*;

  localparam int DB       = DUTY_BITS;
  localparam int DutyMax  = (1 << DUTY_BITS) - 1;
  localparam int DutyQ    = DutyMax / 100;
  localparam int DutyR    = DutyMax % 100;
  localparam int S2W      = 40 + DB;

  // ---------------- configuration registers ----------------
  mode_t       mode_r;
  logic [15:0] tone_a_r, tone_b_r, interval_r, pon_r, poff_r, boost_r;
  logic [20:0] duty_lv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_CONST;
      tone_a_r   <= '0;
      tone_b_r   <= '0;
      interval_r <= '0;
      pon_r      <= '0;
      poff_r     <= '0;
      boost_r    <= '0;
      duty_lv_r  <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_PATTERN_MODE: mode_r     <= mode_t'(cfg_data[2:0]);
        CFG_TONE_A_HZ:    tone_a_r   <= cfg_data[15:0];
        CFG_TONE_B_HZ:    tone_b_r   <= cfg_data[15:0];
        CFG_INTERVAL_MS:  interval_r <= cfg_data[15:0];
        CFG_PULSE_ON_MS:  pon_r      <= cfg_data[15:0];
        CFG_PULSE_OFF_MS: poff_r     <= cfg_data[15:0];
        CFG_BOOST_S:      boost_r    <= cfg_data[15:0];
        CFG_DUTY_LEVELS:  duty_lv_r  <= cfg_data;
      endcase
    end
  end

  // global advance: move unless a finished beat is stuck at the output
  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // ---------------- stage A: input, duty select ----------------
  logic        vld_a_r;
  logic [31:0] t_a_r;
  logic [25:0] boost_ms;
  logic [6:0]  duty_sel, duty_cap, duty_nxt;

  assign boost_ms = 26'(boost_r) * 26'(MS_PER_S);

  always_comb begin
    duty_sel = (in_elapsed_ms < {6'd0, boost_ms}) ? duty_lv_r[6:0] : duty_lv_r[13:7];
    duty_cap = (duty_sel > duty_lv_r[20:14]) ? duty_lv_r[20:14] : duty_sel;
    duty_nxt = (duty_cap > DUTY_FULL) ? DUTY_FULL : duty_cap;
  end

  logic [6:0] duty_a_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
    end else if (en) begin
      vld_a_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_a_r    <= in_elapsed_ms;
      duty_a_r <= duty_nxt;
    end
  end

  // phase divisor per mode
  logic [16:0] pulse_sum, div1_divisor;
  assign pulse_sum = {1'b0, pon_r} + {1'b0, poff_r};

  always_comb begin
    unique case (mode_r)
      MODE_SWEEP: div1_divisor = (interval_r < SWEEP_MIN_MS) ? {1'b0, SWEEP_MIN_MS}
                                                             : {1'b0, interval_r};
      MODE_ALT:   div1_divisor = (interval_r < ALT_MIN_MS) ? {1'b0, ALT_MIN_MS}
                                                           : {1'b0, interval_r};
      MODE_PULSE: div1_divisor = (pulse_sum == 17'd0) ? 17'd1 : pulse_sum;
      MODE_SOS:   div1_divisor = SOS_CYCLE_MS;
      default:    div1_divisor = 17'd1;
    endcase
  end

  // ---------------- divider 1: t mod period ----------------
  logic        d1_vld;
  logic [31:0] d1_quot;
  logic [16:0] d1_rem, d1_div;
  logic [6:0]  d1_duty;

  stpg_divider #(.DW(32), .QW(32), .VW(17), .SW(7)) u_div_phase (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (vld_a_r),
    .dividend (t_a_r),
    .divisor  (div1_divisor),
    .side_in  (duty_a_r),
    .out_vld  (d1_vld),
    .quot     (d1_quot),
    .rem      (d1_rem),
    .div_out  (d1_div),
    .side_out (d1_duty)
  );

  // ---------------- stage B: triangle product, gating ----------------
  logic [17:0] two_p, num18;
  logic [16:0] num;
  logic [15:0] diff_ab;
  logic        sub_nxt, sweep_nxt, on_nxt;
  logic [15:0] fbase_nxt;
  logic [32:0] prod_nxt;

  always_comb begin
    two_p     = {d1_rem, 1'b0};
    num18     = (two_p < {1'b0, d1_div}) ? two_p : {d1_div - d1_rem, 1'b0};
    num       = num18[16:0];
    sub_nxt   = (tone_b_r < tone_a_r);
    diff_ab   = sub_nxt ? (tone_a_r - tone_b_r) : (tone_b_r - tone_a_r);
    sweep_nxt = (mode_r == MODE_SWEEP);
    prod_nxt  = sweep_nxt ? (33'(diff_ab) * 33'(num)) : 33'd0;
    fbase_nxt = tone_a_r;
    unique case (mode_r)
      MODE_CONST: on_nxt = 1'b1;
      MODE_SWEEP: on_nxt = 1'b1;
      MODE_ALT: begin
        on_nxt = 1'b1;
        // odd half period plays the second tone
        if (d1_quot[0]) fbase_nxt = tone_b_r;
      end
      MODE_PULSE: on_nxt = (d1_rem < {1'b0, pon_r});
      MODE_SOS:   on_nxt = sos_on(d1_rem[12:0]);
      default:    on_nxt = 1'b0;
    endcase
  end

  // duty count = duty*q + (duty*r)/100 with DutyMax = 100*q + r
  logic [DB-1:0] dbase_nxt;
  logic [13:0]   dpart_nxt;
  assign dbase_nxt = DB'(DB'(d1_duty) * DB'(DutyQ));
  assign dpart_nxt = 14'(14'(d1_duty) * 14'(DutyR));

  logic            vld_b_r;
  logic [32:0]     prod_b_r;
  logic [16:0]     cyc_b_r;
  logic [S2W-1:0]  side_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_b_r <= 1'b0;
    end else if (en) begin
      vld_b_r <= d1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_b_r <= prod_nxt;
      cyc_b_r  <= d1_div;
      side_b_r <= {on_nxt, sub_nxt, sweep_nxt, fbase_nxt, d1_duty, dpart_nxt, dbase_nxt};
    end
  end

  // ---------------- divider 2: sweep offset ----------------
  logic           d2_vld;
  logic [15:0]    mag;
  logic [S2W-1:0] side_c;

  stpg_divider #(.DW(33), .QW(16), .VW(17), .SW(S2W)) u_div_sweep (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (vld_b_r),
    .dividend (prod_b_r),
    .divisor  (cyc_b_r),
    .side_in  (side_b_r),
    .out_vld  (d2_vld),
    .quot     (mag),
    .rem      (),
    .div_out  (),
    .side_out (side_c)
  );

  // ---------------- stage C: final frequency, output register ----------------
  logic          c_on, c_sub, c_sweep;
  logic [15:0]   c_fbase, freq, freq_cl;
  logic [6:0]    c_duty;
  logic [13:0]   c_dpart;
  logic [DB-1:0] c_dbase, cnt;
  logic [27:0]   frac_prod;

  assign {c_on, c_sub, c_sweep, c_fbase, c_duty, c_dpart, c_dbase} = side_c;

  always_comb begin
    if (c_sweep) begin
      freq = c_sub ? (tone_a_r - mag) : (tone_a_r + mag);
    end else begin
      freq = c_fbase;
    end
    freq_cl   = (freq < MIN_TONE_HZ) ? MIN_TONE_HZ : freq;
    frac_prod = 28'(c_dpart) * 28'(RECIP_100);
    cnt       = c_dbase + DB'(frac_prod >> RECIP_SHIFT);
  end

  logic        out_valid_r, tone_on_r;
  logic [15:0] tone_hz_r;
  logic [6:0]  duty_pct_r;
  logic [9:0]  duty_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= d2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tone_on_r  <= c_on;
      tone_hz_r  <= c_on ? freq_cl : 16'd0;
      duty_pct_r <= c_on ? c_duty : 7'd0;
      duty_cnt_r <= c_on ? 10'(cnt) : 10'd0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_tone_on      = tone_on_r;
  assign out_tone_hz      = tone_hz_r;
  assign out_duty_percent = duty_pct_r;
  assign out_duty_count   = duty_cnt_r;

endmodule

### hw/rtl/stpg_checker.sv
// Port-level checks for the siren tone pattern generator, bound to the top.
`timescale 1ns / 1ps

module stpg_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_tone_on,
  input logic [15:0] out_tone_hz,
  input logic [6:0]  out_duty_percent,
  input logic [9:0]  out_duty_count
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_tone_hz))
    else $error("result beat dropped or changed under stall");

  a_silent_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_tone_on |->
      out_tone_hz == 16'd0 && out_duty_percent == 7'd0 && out_duty_count == 10'd0)
    else $error("silent beat carries nonzero fields");

  a_min_freq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_tone_on |-> out_tone_hz >= 16'd100)
    else $error("sounding tone below floor");

  a_duty_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_duty_percent <= 7'd100)
    else $error("duty above 100 percent");

endmodule

bind siren_tone_pattern_generator stpg_checker u_stpg_checker (.*);
